// ===== rtl/rss_pkg.sv =====
`default_nettype none

package rss_pkg;

    // pattern store geometry
    localparam int PAT_DEPTH = 64;
    localparam int PAT_AW    = $clog2(PAT_DEPTH);

    // field widths
    localparam int VALUE_W    = 12;
    localparam int CHANCE_W   = 7;
    localparam int STEP_W     = 6;
    localparam int TICK_W     = 16;
    localparam int LEN_LOG2_W = 3;
    localparam int FREEDOM_W  = 7;
    localparam int WEIGHT_W   = 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // pattern length limits
    localparam int MIN_LEN_LOG2 = 1;
    localparam int MAX_LEN_LOG2 = 6;
    localparam int LEN_W = ((PAT_AW > MAX_LEN_LOG2) ? PAT_AW : MAX_LEN_LOG2) + 1;

    // chromatic quantizer: k = floor(4v/273) by reciprocal, exact for 12-bit v
    localparam int QK_RECIP   = 15364;
    localparam int QK_SHIFT   = 20;
    localparam int QK_PROD_W  = VALUE_W + 14;
    localparam int K_W        = 6;
    // quantized step is 68.25 codes: q = 68k + ceil(k/4)
    localparam int Q_WHOLE    = 68;
    localparam int Q_FRAC_DIV = 4;
    localparam int Q_FRAC_SH  = 2;
    localparam int DIFF_W     = 7;
    localparam int CALC_W     = VALUE_W + 1;

    // blend weight in 1/128 units
    localparam int W_FULL  = 128;
    localparam int W_SHIFT = 7;
    localparam int BLEND_W = VALUE_W + W_SHIFT;

    // register reset values
    localparam logic [LEN_LOG2_W-1:0] LEN_LOG2_RST     = 3'd3;
    localparam logic                  TRIGGER_ONLY_RST = 1'b0;
    localparam logic [TICK_W-1:0]     PULSE_PERIOD_RST = 16'd4096;
    localparam logic [FREEDOM_W-1:0]  FREEDOM_RST      = 7'd50;
    localparam logic [WEIGHT_W-1:0]   WEIGHT_RST       = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LENGTH_LOG2  = 3'd0,
        REG_TRIGGER_ONLY = 3'd1,
        REG_PULSE_PERIOD = 3'd2,
        REG_FREEDOM      = 3'd3,
        REG_BLEND_WEIGHT = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [LEN_LOG2_W-1:0] length_log2;
        logic                  trigger_only;
        logic [TICK_W-1:0]     pulse_period;
        logic [FREEDOM_W-1:0]  freedom_percent;
        logic [WEIGHT_W-1:0]   blend_weight;
    } cfg_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [CHANCE_W-1:0] chance;
    } blend_item_t;

endpackage

`default_nettype wire

// ===== rtl/rss_cfg_regs.sv =====
`default_nettype none

module rss_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rss_pkg::CFG_DATA_W-1:0] cfg_data,
    output rss_pkg::cfg_t                       cfg
);

    rss_pkg::cfg_t cfg_reg;
    rss_pkg::cfg_t cfg_next;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (rss_pkg::cfg_reg_t'(cfg_index))
                rss_pkg::REG_LENGTH_LOG2:
                    cfg_next.length_log2 = cfg_data[rss_pkg::LEN_LOG2_W-1:0];
                rss_pkg::REG_TRIGGER_ONLY:
                    cfg_next.trigger_only = cfg_data[0];
                rss_pkg::REG_PULSE_PERIOD:
                    cfg_next.pulse_period = cfg_data[rss_pkg::TICK_W-1:0];
                rss_pkg::REG_FREEDOM:
                    cfg_next.freedom_percent = cfg_data[rss_pkg::FREEDOM_W-1:0];
                rss_pkg::REG_BLEND_WEIGHT:
                    cfg_next.blend_weight = cfg_data[rss_pkg::WEIGHT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.length_log2     <= rss_pkg::LEN_LOG2_RST;
            cfg_reg.trigger_only    <= rss_pkg::TRIGGER_ONLY_RST;
            cfg_reg.pulse_period    <= rss_pkg::PULSE_PERIOD_RST;
            cfg_reg.freedom_percent <= rss_pkg::FREEDOM_RST;
            cfg_reg.blend_weight    <= rss_pkg::WEIGHT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rss_blend_pipe.sv =====
`default_nettype none

module rss_blend_pipe (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire rss_pkg::cfg_t                cfg,
    input  wire logic                         tick_valid,
    output logic                              tick_stall,
    input  wire logic [rss_pkg::VALUE_W-1:0]  random_value,
    input  wire logic [rss_pkg::CHANCE_W-1:0] random_chance,
    output logic                              item_valid,
    input  wire logic                         item_ready,
    output rss_pkg::blend_item_t              item
);

    localparam int CW = rss_pkg::CALC_W;
    localparam int BW = rss_pkg::BLEND_W;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic [rss_pkg::VALUE_W-1:0]  s1_value_reg, s2_value_reg, s3_value_reg;
    logic [rss_pkg::CHANCE_W-1:0] s1_chance_reg, s2_chance_reg, s3_chance_reg;
    logic [rss_pkg::K_W-1:0]      s2_k_reg;
    logic [rss_pkg::DIFF_W-1:0]   s3_diff_reg;
    rss_pkg::blend_item_t         s4_item_reg;

    logic [rss_pkg::QK_PROD_W-1:0] k_prod;
    logic [rss_pkg::K_W-1:0]       k_val;
    logic [CW-1:0]                 q_whole, q_frac, diff_full;
    logic [rss_pkg::WEIGHT_W-1:0]  w_sat;
    logic [BW-1:0]                 w_prod, blend_acc;

    // stage ready chain, bubbles collapse
    assign rdy4       = !v4_reg || item_ready;
    assign rdy3       = !v3_reg || rdy4;
    assign rdy2       = !v2_reg || rdy3;
    assign rdy1       = !v1_reg || rdy2;
    assign tick_stall = !rdy1;
    assign item_valid = v4_reg;
    assign item       = s4_item_reg;

    // quantizer index k by reciprocal multiply
    assign k_prod = rss_pkg::QK_PROD_W'(s1_value_reg)
                  * rss_pkg::QK_PROD_W'(rss_pkg::QK_RECIP);
    assign k_val  = k_prod[rss_pkg::QK_SHIFT +: rss_pkg::K_W];

    // distance to the quantized value, v - q
    assign q_whole   = CW'(s2_k_reg) * CW'(rss_pkg::Q_WHOLE);
    assign q_frac    = (CW'(s2_k_reg) + CW'(rss_pkg::Q_FRAC_DIV - 1)) >> rss_pkg::Q_FRAC_SH;
    assign diff_full = CW'(s2_value_reg) - q_whole - q_frac;

    // blend: (q*w + v*(128-w)) >> 7 == (128v - w*(v-q)) >> 7
    assign w_sat     = (cfg.blend_weight > rss_pkg::WEIGHT_W'(rss_pkg::W_FULL))
                     ? rss_pkg::WEIGHT_W'(rss_pkg::W_FULL) : cfg.blend_weight;
    assign w_prod    = BW'(w_sat) * BW'(s3_diff_reg);
    assign blend_acc = (BW'(s3_value_reg) << rss_pkg::W_SHIFT) - w_prod;

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= tick_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (rdy1 && tick_valid)
        begin
            s1_value_reg  <= random_value;
            s1_chance_reg <= random_chance;
        end
        if (rdy2 && v1_reg)
        begin
            s2_value_reg  <= s1_value_reg;
            s2_chance_reg <= s1_chance_reg;
            s2_k_reg      <= k_val;
        end
        if (rdy3 && v2_reg)
        begin
            s3_value_reg  <= s2_value_reg;
            s3_chance_reg <= s2_chance_reg;
            s3_diff_reg   <= diff_full[rss_pkg::DIFF_W-1:0];
        end
        if (rdy4 && v3_reg)
        begin
            s4_item_reg.value  <= blend_acc[rss_pkg::W_SHIFT +: rss_pkg::VALUE_W];
            s4_item_reg.chance <= s3_chance_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rss_step_core.sv =====
`default_nettype none

module rss_step_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire rss_pkg::cfg_t               cfg,
    input  wire logic                        item_valid,
    output logic                             item_ready,
    input  wire rss_pkg::blend_item_t        item,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output logic [rss_pkg::VALUE_W-1:0]      sample_value,
    output logic                             step_fired,
    output logic [rss_pkg::STEP_W-1:0]       step_index
);

    localparam int AW = rss_pkg::PAT_AW;
    localparam int LW = rss_pkg::LEN_W;

    logic [rss_pkg::VALUE_W-1:0] mem [rss_pkg::PAT_DEPTH];
    logic [rss_pkg::VALUE_W-1:0] rdata_reg;

    logic [rss_pkg::PAT_DEPTH-1:0] slot_valid_reg;
    logic [AW-1:0]                 pos_reg, pos_next, pos_wrap;
    logic [rss_pkg::TICK_W-1:0]    tick_reg, tick_inc;
    logic [rss_pkg::VALUE_W-1:0]   held_reg;
    logic                          out_valid_reg;
    logic                          fired_reg;

    logic                          take, fire, refill, step_write;
    logic [rss_pkg::VALUE_W-1:0]   slot_cur, slot_new;
    logic [rss_pkg::LEN_LOG2_W-1:0] len_log2;
    logic [LW-1:0]                 len_pow, len, len_last;

    assign item_ready   = !out_valid_reg || !result_stall;
    assign take         = item_valid && item_ready;
    assign result_valid = out_valid_reg;
    assign sample_value = held_reg;
    assign step_fired   = fired_reg;
    assign step_index   = rss_pkg::STEP_W'(pos_reg);

    // pattern length, clamped to the legal range and the store depth
    always_comb
    begin
        priority if (cfg.length_log2 < rss_pkg::LEN_LOG2_W'(rss_pkg::MIN_LEN_LOG2))
        begin
            len_log2 = rss_pkg::LEN_LOG2_W'(rss_pkg::MIN_LEN_LOG2);
        end
        else if (cfg.length_log2 > rss_pkg::LEN_LOG2_W'(rss_pkg::MAX_LEN_LOG2))
        begin
            len_log2 = rss_pkg::LEN_LOG2_W'(rss_pkg::MAX_LEN_LOG2);
        end
        else
        begin
            len_log2 = cfg.length_log2;
        end
    end

    assign len_pow  = LW'(1) << len_log2;
    assign len      = (len_pow > LW'(rss_pkg::PAT_DEPTH)) ? LW'(rss_pkg::PAT_DEPTH) : len_pow;
    assign len_last = len - LW'(1);
    assign pos_wrap = (LW'(pos_reg) < len_last) ? pos_reg + AW'(1) : '0;

    // tick counter and step decision
    assign tick_inc = (tick_reg == '1) ? tick_reg : tick_reg + rss_pkg::TICK_W'(1);
    assign fire     = cfg.trigger_only || (tick_inc > cfg.pulse_period);

    // current slot: read data always tracks the slot at pos_reg
    assign slot_cur   = slot_valid_reg[pos_reg] ? rdata_reg : '0;
    assign refill     = (slot_cur == '0) || (item.chance < cfg.freedom_percent);
    assign slot_new   = refill ? item.value : slot_cur;
    assign step_write = take && fire && refill;
    assign pos_next   = (take && fire) ? pos_wrap : pos_reg;

    // pattern memory, read at the position of the next cycle
    always_ff @(posedge clk)
    begin
        if (step_write)
        begin
            mem[pos_reg] <= item.value;
        end
        rdata_reg <= mem[pos_next];
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            pos_reg        <= '0;
            tick_reg       <= '0;
            held_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= 1'b1;
                if (fire)
                begin
                    tick_reg <= '0;
                    held_reg <= slot_new;
                    pos_reg  <= pos_wrap;
                end
                else
                begin
                    tick_reg <= tick_inc;
                end
                if (step_write)
                begin
                    slot_valid_reg[pos_reg] <= 1'b1;
                end
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result flag
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            fired_reg <= fire;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/random_step_sequencer.sv =====
`default_nettype none
// path: a taken tick reaches the result register through the input register, quantizer index,
// quantizer distance, blend multiply and step stage registers in that order
// throughput: one tick per cycle when not stalled; the pattern slot is read from a registered memory port
// reset: configuration takes its defaults, position, tick count and output go to zero,
// and the pattern reads as all zeros at once through per-slot valid flags (no clear pass)

module random_step_sequencer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           tick_valid,
    output logic                                tick_stall,
    input  wire logic [rss_pkg::VALUE_W-1:0]    random_value,
    input  wire logic [rss_pkg::CHANCE_W-1:0]   random_chance,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic [rss_pkg::VALUE_W-1:0]         sample_value,
    output logic                                step_fired,
    output logic [rss_pkg::STEP_W-1:0]          step_index,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rss_pkg::CFG_DATA_W-1:0] cfg_data
);

    rss_pkg::cfg_t        cfg;
    rss_pkg::blend_item_t item;
    logic                 item_valid;
    logic                 item_ready;

    rss_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rss_blend_pipe u_blend (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .tick_valid    (tick_valid),
        .tick_stall    (tick_stall),
        .random_value  (random_value),
        .random_chance (random_chance),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item)
    );

    rss_step_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sample_value (sample_value),
        .step_fired   (step_fired),
        .step_index   (step_index)
    );

endmodule

`default_nettype wire

// ===== rtl/rss_checker.sv =====
`default_nettype none

module rss_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           tick_stall,
    input wire logic                           result_valid,
    input wire logic                           result_stall,
    input wire logic [rss_pkg::VALUE_W-1:0]    sample_value,
    input wire logic                           step_fired,
    input wire logic [rss_pkg::STEP_W-1:0]     step_index
);

    logic [rss_pkg::VALUE_W-1:0] prev_sample_reg;
    logic [rss_pkg::STEP_W-1:0]  prev_index_reg;
    logic                        result_take;

    assign result_take = result_valid && !result_stall;

    // last delivered result, zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg <= '0;
            prev_index_reg  <= '0;
        end
        else if (result_take)
        begin
            prev_sample_reg <= sample_value;
            prev_index_reg  <= step_index;
        end
    end

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid
            && $stable(sample_value) && $stable(step_fired) && $stable(step_index))
    else $error("stalled result changed");

    // an empty result register never blocks new ticks
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !tick_stall)
    else $error("tick stalled with empty result register");

    // without a step the output and position are held
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !step_fired |->
            sample_value == prev_sample_reg && step_index == prev_index_reg)
    else $error("output moved without a step");

    // a step advances the position by one or wraps to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && step_fired |->
            step_index == '0
            || step_index == rss_pkg::STEP_W'(prev_index_reg + rss_pkg::STEP_W'(1)))
    else $error("step position skipped");

endmodule

bind random_step_sequencer rss_checker u_rss_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;

    // predictor constants
    localparam int unsigned SEMITONE_X100 = 6825;
    localparam int unsigned PERCENT       = 100;
    localparam int unsigned WEIGHT_FULL   = 128;
    localparam int unsigned WEIGHT_SH     = 7;
    localparam int          DRAIN_CYCLES  = 10;
    localparam int          RANDOM_PHASES = 12;
    localparam int          PHASE_TICKS   = 125;
    localparam int          LONG_PERIOD_TICKS = 40;

    // tracks the sequencer state and the results still owed by the block
    class step_scoreboard;
        typedef struct packed {
            logic [rss_pkg::VALUE_W-1:0] value;
            logic                        fired;
            logic [rss_pkg::STEP_W-1:0]  index;
        } step_result_t;

        logic [rss_pkg::VALUE_W-1:0]    pattern [rss_pkg::PAT_DEPTH];
        logic [rss_pkg::STEP_W-1:0]     position;
        logic [rss_pkg::TICK_W-1:0]     ticks;
        logic [rss_pkg::VALUE_W-1:0]    held;
        logic [rss_pkg::LEN_LOG2_W-1:0] len_log2;
        logic                           trig;
        logic [rss_pkg::TICK_W-1:0]     period;
        logic [rss_pkg::FREEDOM_W-1:0]  freedom;
        logic [rss_pkg::WEIGHT_W-1:0]   weight;
        step_result_t                   owed_steps [$];
        int                             errors;
        int                             checked;
        int                             steps_fired;

        function new();
            foreach (pattern[i]) pattern[i] = '0;
            position = '0;
            ticks    = '0;
            held     = '0;
            len_log2 = rss_pkg::LEN_LOG2_RST;
            trig     = rss_pkg::TRIGGER_ONLY_RST;
            period   = rss_pkg::PULSE_PERIOD_RST;
            freedom  = rss_pkg::FREEDOM_RST;
            weight   = rss_pkg::WEIGHT_RST;
            errors = 0;
            checked = 0;
            steps_fired = 0;
        endfunction

        function int pending();
            return owed_steps.size();
        endfunction

        function void configure(rss_pkg::cfg_reg_t r, logic [rss_pkg::CFG_DATA_W-1:0] d);
            case (r)
                rss_pkg::REG_LENGTH_LOG2:  len_log2 = d[rss_pkg::LEN_LOG2_W-1:0];
                rss_pkg::REG_TRIGGER_ONLY: trig     = d[0];
                rss_pkg::REG_PULSE_PERIOD: period   = d[rss_pkg::TICK_W-1:0];
                rss_pkg::REG_FREEDOM:      freedom  = d[rss_pkg::FREEDOM_W-1:0];
                rss_pkg::REG_BLEND_WEIGHT: weight   = d[rss_pkg::WEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        // mix of the raw draw and its semitone-quantized value
        function logic [rss_pkg::VALUE_W-1:0] blend(logic [rss_pkg::VALUE_W-1:0] v);
            int unsigned vi;
            int unsigned q;
            int unsigned w;
            int unsigned mixed;
            vi = v;
            q = vi - ((vi * PERCENT) % SEMITONE_X100) / PERCENT;
            w = (weight > WEIGHT_FULL) ? WEIGHT_FULL : weight;
            mixed = (q * w + vi * (WEIGHT_FULL - w)) >> WEIGHT_SH;
            return mixed[rss_pkg::VALUE_W-1:0];
        endfunction

        function void note_tick(logic [rss_pkg::VALUE_W-1:0] v,
                                logic [rss_pkg::CHANCE_W-1:0] c);
            step_result_t r;
            int unsigned  l;
            int unsigned  len;
            if (ticks != '1)
                ticks++;
            r.fired = 1'b0;
            if (trig || ticks > period)
            begin
                l = len_log2;
                if (l < rss_pkg::MIN_LEN_LOG2) l = rss_pkg::MIN_LEN_LOG2;
                if (l > rss_pkg::MAX_LEN_LOG2) l = rss_pkg::MAX_LEN_LOG2;
                len = 1 << l;
                if (len > rss_pkg::PAT_DEPTH) len = rss_pkg::PAT_DEPTH;
                if (pattern[position] == '0 || c < freedom)
                    pattern[position] = blend(v);
                held = pattern[position];
                if (position < len - 1)
                    position++;
                else
                    position = '0;
                ticks = '0;
                r.fired = 1'b1;
                steps_fired++;
            end
            r.value = held;
            r.index = position;
            owed_steps.push_back(r);
        endfunction

        function void report(string msg);
            errors++;
            $display("%0t: %s", $time, msg);
        endfunction

        function void compare(string field, int unsigned exp, int unsigned act);
            if (exp != act)
                report($sformatf("%s mismatch on item %0d, expected %0d, actual %0d",
                                 field, checked, exp, act));
        endfunction

        function void check_result(logic [rss_pkg::VALUE_W-1:0] v, logic f,
                                   logic [rss_pkg::STEP_W-1:0] idx);
            step_result_t e;
            if (owed_steps.size() == 0)
            begin
                report($sformatf("result with nothing owed, value %0d fired %0d index %0d",
                                 v, f, idx));
                return;
            end
            e = owed_steps.pop_front();
            compare("sample_value", e.value, v);
            compare("step_fired", e.fired, f);
            compare("step_index", e.index, idx);
            checked++;
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           tick_valid = 1'b0;
    logic                           tick_stall;
    logic [rss_pkg::VALUE_W-1:0]    random_value = '0;
    logic [rss_pkg::CHANCE_W-1:0]   random_chance = '0;
    logic                           result_valid;
    logic                           result_stall = 1'b0;
    logic [rss_pkg::VALUE_W-1:0]    sample_value;
    logic                           step_fired;
    logic [rss_pkg::STEP_W-1:0]     step_index;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [rss_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rss_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    step_scoreboard sb;
    int             send_idle_pct = 0;
    int             stall_pct = 0;
    int             cfg_writes = 0;

    random_step_sequencer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_valid    (tick_valid),
        .tick_stall    (tick_stall),
        .random_value  (random_value),
        .random_chance (random_chance),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .sample_value  (sample_value),
        .step_fired    (step_fired),
        .step_index    (step_index),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // receiver back-pressure
    always @(negedge clk)
        result_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

    // accepted ticks feed the predictor
    always @(posedge clk)
        if (rst_n && tick_valid && !tick_stall)
            sb.note_tick(random_value, random_chance);

    // accepted results are checked in order
    always @(posedge clk)
        if (rst_n && result_valid && !result_stall)
            sb.check_result(sample_value, step_fired, step_index);

    // one tick, with random idle cycles ahead of it; starts and ends at a falling edge
    task automatic send_tick(logic [rss_pkg::VALUE_W-1:0] v,
                             logic [rss_pkg::CHANCE_W-1:0] c);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            tick_valid <= 1'b0;
            @(negedge clk);
        end
        tick_valid    <= 1'b1;
        random_value  <= v;
        random_chance <= c;
        do @(posedge clk); while (tick_stall !== 1'b0);
        @(negedge clk);
    endtask

    task automatic write_cfg(rss_pkg::cfg_reg_t r, int d);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= rss_pkg::CFG_DATA_W'(d);
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.configure(r, rss_pkg::CFG_DATA_W'(d));
        cfg_writes++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // all registers, written once the block has gone quiet
    task automatic set_config(int len, int trig, int period, int freedom, int weight);
        tick_valid <= 1'b0;
        wait_drained();
        write_cfg(rss_pkg::REG_LENGTH_LOG2, len);
        write_cfg(rss_pkg::REG_TRIGGER_ONLY, trig);
        write_cfg(rss_pkg::REG_PULSE_PERIOD, period);
        write_cfg(rss_pkg::REG_FREEDOM, freedom);
        write_cfg(rss_pkg::REG_BLEND_WEIGHT, weight);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int n);
        logic [rss_pkg::VALUE_W-1:0]  v;
        logic [rss_pkg::CHANCE_W-1:0] c;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 19))
                0, 1:    v = '0;
                2:       v = '1;
                default: v = rss_pkg::VALUE_W'($urandom_range(0, 4095));
            endcase
            c = rss_pkg::CHANCE_W'($urandom_range(0, 127));
            send_tick(v, c);
        end
    endtask

    // watchdog
    initial
    begin
        #4000000;
        $display("timeout with %0d results still owed", sb.pending());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int len;
        int trig;
        int period;
        int freedom;
        int weight;

        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // reset defaults: counter runs, no step yet
        send_tick('1, 7'd127);
        send_tick('0, 7'd0);

        // shortest pattern via clamped zero length, refill only empty slots
        set_config(0, 1, 4096, 0, 0);
        send_tick(12'd0, 7'd0);
        send_tick(12'd4095, 7'd127);
        send_tick(12'd1234, 7'd0);
        send_tick(12'd77, 7'd0);

        // longest pattern via clamped length, weight saturates, full freedom
        set_config(7, 1, 4096, 100, 255);
        send_tick(12'd4095, 7'd99);
        send_tick(12'd2048, 7'd100);
        send_tick(12'd3000, 7'd127);
        send_tick(12'd1, 7'd0);
        send_tick(12'd4095, 7'd0);
        send_tick(12'd68, 7'd50);

        // shortened length leaves the position past the end
        set_config(1, 1, 4096, 50, 64);
        send_tick(12'd2730, 7'd10);
        send_tick(12'd100, 7'd90);

        // pulse period zero steps every tick, period one every other tick
        set_config(1, 0, 0, 127, 128);
        send_tick(12'd555, 7'd3);
        send_tick(12'd3333, 7'd64);
        set_config(2, 0, 1, 0, 1);
        send_tick(12'd2222, 7'd1);
        send_tick(12'd1111, 7'd2);
        send_tick(12'd999, 7'd4);

        // top period holds the counter climbing, then a shorter period fires at once
        set_config(3, 0, 65535, 50, 32);
        run_random(LONG_PERIOD_TICKS);
        set_config(3, 0, LONG_PERIOD_TICKS / 2, 50, 32);
        send_tick(12'd4000, 7'd8);

        // random phases: sender-light idling, then receiver-light, then none
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p / 4)
                0:
                begin
                    send_idle_pct = 29;
                    stall_pct = 84;
                end
                1:
                begin
                    send_idle_pct = 84;
                    stall_pct = 29;
                end
                default:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
            endcase
            len = $urandom_range(0, 7);
            trig = $urandom_range(0, 1);
            period = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 40) : $urandom_range(0, 3);
            freedom = $urandom_range(0, 127);
            case ($urandom_range(0, 3))
                0:       weight = 0;
                1:       weight = 128;
                2:       weight = 255;
                default: weight = $urandom_range(0, 255);
            endcase
            // register extremes early in each idling mode
            case (p % 4)
                0:
                begin
                    len = 1;
                    trig = 1;
                    period = 0;
                    freedom = 0;
                    weight = 0;
                end
                1:
                begin
                    len = 6;
                    trig = 0;
                    period = 0;
                    freedom = 100;
                    weight = 128;
                end
                2:
                begin
                    len = 7;
                    trig = 1;
                    period = 65535;
                    freedom = 127;
                    weight = 255;
                end
                default: ;
            endcase
            set_config(len, trig, period, freedom, weight);
            run_random(PHASE_TICKS);
        end

        tick_valid <= 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d ticks (%0d steps fired) over %0d register writes",
                 sb.checked, sb.steps_fired, cfg_writes);
        $display("covered clamped lengths, saturated weight, long periods and mixed idling");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
